>>> sv/cpd_pkg.sv
package cpd_pkg;

   localparam int POS_W      = 32;
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int PAIRS_W    = 11;
   localparam int THR_W      = 31;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 31'd1677722;
   localparam logic [PAIRS_W-1:0] PAIRS_MAX       = 11'h7FF;

   // Register index as decoded from the word address.
   localparam logic REG_THRESHOLD = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SCAN,
      ST_TOTAL
   } cpd_state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } cpd_pos_type;

   // One slot of the hit lane that runs down the cell chain.
   typedef struct packed {
      logic        hit;
      cpd_pos_type pos;
   } cpd_lane_type;

   typedef struct packed {
      logic compare;
      logic shift;
   } cpd_cell_ctl_type;

   typedef struct packed {
      logic [IDX_W-1:0]   earlier_index;
      cpd_pos_type        earlier;
      logic [IDX_W-1:0]   later_index;
      cpd_pos_type        later;
      logic               is_total;
      logic [PAIRS_W-1:0] pair_total;
      logic               overflow;
      logic               last_result;
   } cpd_result_type;

   // Strict per-axis test |a - b| < thr on sign-extended coordinates.
   function automatic logic axis_close(input logic [POS_W-1:0] a,
                                       input logic [POS_W-1:0] b,
                                       input logic [THR_W-1:0] thr);
      logic signed [POS_W:0] diff;
      logic signed [POS_W:0] lim;
      diff = {a[POS_W-1], a} - {b[POS_W-1], b};
      lim  = {2'b00, thr};
      return (diff < lim) && (diff > -lim);
   endfunction

endpackage

>>> sv/close_pair_detector_unit.sv
// Close pair detector.
// Requests carry one particle position (req_pos_x/y/z, signed Q8.24) and the
// req_last_particle flag on a valid/ready channel. Each particle is compared
// with every earlier particle of its set in a chain of cells, one cell per
// stored particle, and every close pair is returned on the rsp_ channel in
// increasing earlier index. A request marked last is followed by a count
// record (rsp_is_total = 1) and the set is emptied. The APB-style port holds
// the per-axis threshold at address 0.
// Timing: a request is taken in the idle state and compared in the next
// cycle; the hit lane then moves down the chain one cell per cycle toward
// the output stage unless a hit at its head waits for a stalled receiver.
// A pair with earlier index k moves from cell k down to cell 0 and then
// into the output register. A request passes through the compare and scan
// states, the scan lasting until the hit lane has drained, and one marked
// last also through the total state for the count record. New requests are
// taken only when the previous one is done. Reset empties the set, clears
// the pair count and the overflow flag and sets the threshold to 0.1; stored
// positions are not cleared. When the receiver stalls, the output register
// holds its record and the lane stops shifting once a hit reaches its head.
module close_pair_detector_unit
   import cpd_pkg::*;
#(
   parameter int MAX_PARTICLES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [POS_W-1:0]      req_pos_x,
   input  logic signed [POS_W-1:0]      req_pos_y,
   input  logic signed [POS_W-1:0]      req_pos_z,
   input  logic                         req_last_particle,
   // Result channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [IDX_W-1:0]             rsp_earlier_index,
   output logic signed [POS_W-1:0]      rsp_earlier_x,
   output logic signed [POS_W-1:0]      rsp_earlier_y,
   output logic signed [POS_W-1:0]      rsp_earlier_z,
   output logic [IDX_W-1:0]             rsp_later_index,
   output logic signed [POS_W-1:0]      rsp_later_x,
   output logic signed [POS_W-1:0]      rsp_later_y,
   output logic signed [POS_W-1:0]      rsp_later_z,
   output logic                         rsp_is_total,
   output logic [PAIRS_W-1:0]           rsp_pair_total,
   output logic                         rsp_overflow,
   output logic                         rsp_last_result,
   // Configuration port.
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(MAX_PARTICLES);

   // Control state.
   cpd_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PAIRS_W-1:0]   pairs_ff, pairs_in;
   logic                 dropped_ff, dropped_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [THR_W-1:0]     thr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Request payload held for the duration of the request.
   cpd_pos_type          new_pos_ff;
   logic                 new_last_ff;
   logic [IDX_W-1:0]     new_idx_ff, new_idx_in;

   cpd_result_type       rsp_ff, rsp_in;

   cpd_cell_ctl_type     cell_ctl;
   cpd_lane_type         lanes [0:MAX_PARTICLES];
   logic [MAX_PARTICLES-1:0] hit_vec;
   logic                 any_hit;
   logic                 more_hits;
   logic                 slot_free;
   logic                 csr_write;

   // ------------------------------------------------------------------
   // Configuration port: one threshold register, word addressed.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_write && (paddr[2] == REG_THRESHOLD)) begin
         thr_ff <= pwdata[THR_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_THRESHOLD) begin
         prdata = {1'b0, thr_ff};
      end else begin
         prdata = '0;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain. Cell i stores particle i; its hit lane slot feeds cell i-1
   // during the scan so that the head of the lane is always at cell 0.
   // ------------------------------------------------------------------
   assign lanes[MAX_PARTICLES] = '0;

   for (genvar gi = 0; gi < MAX_PARTICLES; gi++) begin : g_cell
      cpd_cell #(
         .CELL_INDEX (gi)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .new_pos      (new_pos_ff),
         .threshold    (thr_ff),
         .stored_count (count_ff),
         .lane_up      (lanes[gi+1]),
         .lane_out     (lanes[gi])
      );
      assign hit_vec[gi] = lanes[gi].hit;
   end

   assign any_hit   = |hit_vec;
   assign more_hits = |hit_vec[MAX_PARTICLES-1:1];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pairs_ff     <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pairs_ff     <= pairs_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         new_pos_ff.x <= req_pos_x;
         new_pos_ff.y <= req_pos_y;
         new_pos_ff.z <= req_pos_z;
         new_last_ff  <= req_last_particle;
      end
      new_idx_ff <= new_idx_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pairs_in     = pairs_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      new_idx_in   = new_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cell_ctl     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            idx_in = '0;
            if (count_ff < CAPACITY) begin
               cell_ctl.compare = 1'b1;
               new_idx_in       = count_ff[IDX_W-1:0];
               count_in         = count_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!any_hit) begin
               state_in = new_last_ff ? ST_TOTAL : ST_IDLE;
            end else if (!lanes[0].hit) begin
               cell_ctl.shift = 1'b1;
               idx_in         = idx_ff + 1'b1;
            end else if (slot_free) begin
               cell_ctl.shift       = 1'b1;
               idx_in               = idx_ff + 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.earlier_index = idx_ff;
               rsp_in.earlier       = lanes[0].pos;
               rsp_in.later_index   = new_idx_ff;
               rsp_in.later         = new_pos_ff;
               rsp_in.is_total      = 1'b0;
               rsp_in.pair_total    = '0;
               rsp_in.overflow      = 1'b0;
               rsp_in.last_result   = !more_hits && !new_last_ff;
               if (pairs_ff != PAIRS_MAX) begin
                  pairs_in = pairs_ff + 1'b1;
               end
            end
         end
         ST_TOTAL: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.is_total      = 1'b1;
               rsp_in.pair_total    = pairs_ff;
               rsp_in.overflow      = dropped_ff;
               rsp_in.last_result   = 1'b1;
               count_in             = '0;
               pairs_in             = '0;
               dropped_in           = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_earlier_index = rsp_ff.earlier_index;
   assign rsp_earlier_x     = rsp_ff.earlier.x;
   assign rsp_earlier_y     = rsp_ff.earlier.y;
   assign rsp_earlier_z     = rsp_ff.earlier.z;
   assign rsp_later_index   = rsp_ff.later_index;
   assign rsp_later_x       = rsp_ff.later.x;
   assign rsp_later_y       = rsp_ff.later.y;
   assign rsp_later_z       = rsp_ff.later.z;
   assign rsp_is_total      = rsp_ff.is_total;
   assign rsp_pair_total    = rsp_ff.pair_total;
   assign rsp_overflow      = rsp_ff.overflow;
   assign rsp_last_result   = rsp_ff.last_result;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The set never holds more particles than there are cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("stored particle count exceeds capacity");

   // A new request never starts while hits of the previous one are pending.
   a_idle_lane_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !any_hit)
      else $error("hit lane not drained when idle");

   // The count record is only produced for a request marked last.
   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOTAL) |-> new_last_ff)
      else $error("count record without last particle");

   // Emitting the count record empties the set.
   a_total_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOTAL && slot_free) |=>
         (count_ff == '0 && pairs_ff == '0 && !dropped_ff))
      else $error("set not cleared after count record");

endmodule

>>> sv/cpd_cell.sv
module cpd_cell
   import cpd_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpd_cell_ctl_type     ctl,
   input  cpd_pos_type          new_pos,
   input  logic [THR_W-1:0]     threshold,
   input  logic [COUNT_W-1:0]   stored_count,
   input  cpd_lane_type         lane_up,
   output cpd_lane_type         lane_out
);

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(CELL_INDEX);

   cpd_pos_type pos_ff;
   logic        hit_ff;
   cpd_pos_type lane_pos_ff;
   logic        occupied;
   logic        close;

   // The cell holds a particle only below the fill level of the current set.
   assign occupied = stored_count > MY_INDEX;
   assign close = occupied &&
                  axis_close(pos_ff.x, new_pos.x, threshold) &&
                  axis_close(pos_ff.y, new_pos.y, threshold) &&
                  axis_close(pos_ff.z, new_pos.z, threshold);

   always_ff @(posedge clock) begin
      if (ctl.compare && (stored_count == MY_INDEX)) begin
         pos_ff <= new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.compare) begin
         hit_ff <= close;
      end else if (ctl.shift) begin
         hit_ff <= lane_up.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.compare) begin
         lane_pos_ff <= pos_ff;
      end else if (ctl.shift) begin
         lane_pos_ff <= lane_up.pos;
      end
   end

   assign lane_out.hit = hit_ff;
   assign lane_out.pos = lane_pos_ff;

endmodule

>>> tb/tb_close_pair_detector_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the close pair detector.
// Particles are queued per set by the stimulus process, offered by a driver
// process and predicted when their request is accepted. A monitor process
// checks every returned record against the oldest predicted record.
module tb_close_pair_detector_unit;
   import cpd_pkg::*;

   localparam int SET_CAPACITY    = 64;
   localparam int CYCLE_LIMIT     = 4000000;
   // A request can occupy the block until its hit lane has drained through every cell; allow for stalls.
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_SHOWN       = 10;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
   localparam logic [POS_W-1:0]      POS_MAX        = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0]      POS_MIN        = 32'h8000_0000;
   localparam logic [THR_W-1:0]      THR_MAX        = '1;

   typedef struct packed {
      cpd_pos_type pos;
      logic        last;
   } particle_req_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic signed [POS_W-1:0] req_pos_x         = '0;
   logic signed [POS_W-1:0] req_pos_y         = '0;
   logic signed [POS_W-1:0] req_pos_z         = '0;
   logic                    req_last_particle = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic [IDX_W-1:0]        rsp_earlier_index;
   logic signed [POS_W-1:0] rsp_earlier_x;
   logic signed [POS_W-1:0] rsp_earlier_y;
   logic signed [POS_W-1:0] rsp_earlier_z;
   logic [IDX_W-1:0]        rsp_later_index;
   logic signed [POS_W-1:0] rsp_later_x;
   logic signed [POS_W-1:0] rsp_later_y;
   logic signed [POS_W-1:0] rsp_later_z;
   logic                    rsp_is_total;
   logic [PAIRS_W-1:0]      rsp_pair_total;
   logic                    rsp_overflow;
   logic                    rsp_last_result;
   logic                    psel              = 1'b0;
   logic                    penable           = 1'b0;
   logic                    pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr             = '0;
   logic [CSR_DATA_W-1:0]   pwdata            = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   // Our own copy of the particle set and of the threshold register.
   cpd_pos_type      stored_pos [SET_CAPACITY];
   int               set_size     = 0;
   int               pairs_in_set = 0;
   bit               set_dropped  = 1'b0;
   logic [THR_W-1:0] thr_model    = THRESHOLD_RESET;

   cpd_result_type   expected_records [$];
   particle_req_type pending_particles [$];
   particle_req_type offered;

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int cycle_count    = 0;

   // When calm is set neither side inserts random idle cycles.
   bit   calm           = 1'b0;
   bit   pressure_armed = 1'b0;
   logic hold_off       = 1'b0;

   close_pair_detector_unit #(
      .MAX_PARTICLES(SET_CAPACITY)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_last_particle(req_last_particle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_earlier_index(rsp_earlier_index),
      .rsp_earlier_x    (rsp_earlier_x),
      .rsp_earlier_y    (rsp_earlier_y),
      .rsp_earlier_z    (rsp_earlier_z),
      .rsp_later_index  (rsp_later_index),
      .rsp_later_x      (rsp_later_x),
      .rsp_later_y      (rsp_later_y),
      .rsp_later_z      (rsp_later_z),
      .rsp_is_total     (rsp_is_total),
      .rsp_pair_total   (rsp_pair_total),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is cut off with an error once it reaches the cycle limit, as when the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Strict per-axis test on the full signed difference, so that opposite
   // extremes never wrap into a small distance.
   function automatic bit axis_near(input logic signed [POS_W-1:0] a,
                                    input logic signed [POS_W-1:0] b);
      longint delta;
      delta = longint'(a) - longint'(b);
      if (delta < 0) delta = -delta;
      return delta < longint'(thr_model);
   endfunction

   // Works out every record that one accepted request causes: one pair
   // record per close earlier particle, in increasing earlier index, then a
   // count record when the request closes the set.
   task automatic predict_close_pairs(input particle_req_type p);
      cpd_result_type batch [SET_CAPACITY + 1];
      int             produced;
      produced = 0;
      if (set_size < SET_CAPACITY) begin
         for (int k = 0; k < set_size; k++) begin
            if (axis_near(stored_pos[k].x, p.pos.x) &&
                axis_near(stored_pos[k].y, p.pos.y) &&
                axis_near(stored_pos[k].z, p.pos.z)) begin
               batch[produced]               = '0;
               batch[produced].earlier_index = IDX_W'(k);
               batch[produced].earlier       = stored_pos[k];
               batch[produced].later_index   = IDX_W'(set_size);
               batch[produced].later         = p.pos;
               produced++;
               if (pairs_in_set < int'(PAIRS_MAX)) pairs_in_set++;
            end
         end
         stored_pos[set_size] = p.pos;
         set_size++;
      end else begin
         // The set is full: the particle is dropped without any comparison.
         set_dropped = 1'b1;
      end
      if (p.last) begin
         batch[produced]            = '0;
         batch[produced].is_total   = 1'b1;
         batch[produced].pair_total = PAIRS_W'(pairs_in_set);
         batch[produced].overflow   = set_dropped;
         produced++;
         set_size     = 0;
         pairs_in_set = 0;
         set_dropped  = 1'b0;
      end
      if (produced > 0) batch[produced - 1].last_result = 1'b1;
      for (int k = 0; k < produced; k++) expected_records.push_back(batch[k]);
   endtask

   // ---------------------------------------------------------------------
   // Idle patterns
   // ---------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_length();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // A request is predicted at the edge where it is accepted. The next one
   // is put up only once the slot is free, so valid and the payload hold
   // steady while the block is busy.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_close_pairs(offered);
            accepted_count++;
            send_gap = idle_length();
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_particles.size() > 0) begin
               offered = pending_particles.pop_front();
               req_valid         <= 1'b1;
               req_pos_x         <= offered.pos.x;
               req_pos_y         <= offered.pos.y;
               req_pos_z         <= offered.pos.z;
               req_last_particle <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------------

   function automatic string record_text(input cpd_result_type r);
      return $sformatf({"earlier %0d (%h %h %h) later %0d (%h %h %h) ",
                        "total %b pairs %0d ovf %b last %b"},
                       r.earlier_index, r.earlier.x, r.earlier.y, r.earlier.z,
                       r.later_index, r.later.x, r.later.y, r.later.z,
                       r.is_total, r.pair_total, r.overflow, r.last_result);
   endfunction

   // Only the first few failures are printed; the rest are just counted.
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) $display("%s", msg);
   endtask

   task automatic check_result();
      cpd_result_type seen;
      cpd_result_type want;
      string          bad;
      seen.earlier_index = rsp_earlier_index;
      seen.earlier.x     = rsp_earlier_x;
      seen.earlier.y     = rsp_earlier_y;
      seen.earlier.z     = rsp_earlier_z;
      seen.later_index   = rsp_later_index;
      seen.later.x       = rsp_later_x;
      seen.later.y       = rsp_later_y;
      seen.later.z       = rsp_later_z;
      seen.is_total      = rsp_is_total;
      seen.pair_total    = rsp_pair_total;
      seen.overflow      = rsp_overflow;
      seen.last_result   = rsp_last_result;
      if (expected_records.size() == 0) begin
         flag_mismatch($sformatf("result with nothing expected: %s",
                                 record_text(seen)));
      end else begin
         want = expected_records.pop_front();
         bad  = "";
         if (seen.earlier_index !== want.earlier_index) bad = {bad, " earlier_index"};
         if (seen.earlier.x !== want.earlier.x)         bad = {bad, " earlier_x"};
         if (seen.earlier.y !== want.earlier.y)         bad = {bad, " earlier_y"};
         if (seen.earlier.z !== want.earlier.z)         bad = {bad, " earlier_z"};
         if (seen.later_index !== want.later_index)     bad = {bad, " later_index"};
         if (seen.later.x !== want.later.x)             bad = {bad, " later_x"};
         if (seen.later.y !== want.later.y)             bad = {bad, " later_y"};
         if (seen.later.z !== want.later.z)             bad = {bad, " later_z"};
         if (seen.is_total !== want.is_total)           bad = {bad, " is_total"};
         if (seen.pair_total !== want.pair_total)       bad = {bad, " pair_total"};
         if (seen.overflow !== want.overflow)           bad = {bad, " overflow"};
         if (seen.last_result !== want.last_result)     bad = {bad, " last_result"};
         if (bad != "") begin
            flag_mismatch($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                    bad, record_text(want), record_text(seen)));
         end
      end
   endtask

   // Ready drops for random stretches, both right after a result and at
   // arbitrary points of the block's work, and for the whole hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (stall_left == 0 && ((rsp_valid && rsp_ready) || $urandom_range(0, 15) == 0))
            stall_left = idle_length();
         if (hold_off || stall_left > 0) begin
            if (stall_left > 0) stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // The receiver goes quiet for a long stretch while a dense set is being
   // sent, so the output and the hit lane back up into the request side.
   initial begin
      wait (pressure_armed);
      repeat (30) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Configuration access
   // ---------------------------------------------------------------------

   task automatic write_threshold(input logic [THR_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= THRESHOLD_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      thr_model = value;
   endtask

   // Reads the register back during the access cycle.
   task automatic verify_threshold();
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= THRESHOLD_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== CSR_DATA_W'(thr_model)) begin
         flag_mismatch($sformatf("threshold read back: expected %h actual %h",
                                 CSR_DATA_W'(thr_model), got));
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic queue_particle(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [POS_W-1:0] z, input logic last);
      particle_req_type p;
      p.pos.x = x;
      p.pos.y = y;
      p.pos.z = z;
      p.last  = last;
      pending_particles.push_back(p);
      queued_count++;
   endtask

   function automatic logic [POS_W-1:0] jitter(input int unsigned spread);
      return POS_W'($urandom_range(0, 2 * spread)) - POS_W'(spread);
   endfunction

   // One well-formed set: particles scattered around a random center, with
   // some copies of earlier particles and some fully random outliers. Only
   // the final particle carries the last flag.
   task automatic queue_cluster_set(input int count, input int unsigned spread,
                                    input int noise_pct);
      cpd_pos_type center;
      cpd_pos_type p;
      cpd_pos_type picked [128];
      int          roll;
      center = {$urandom, $urandom, $urandom};
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < noise_pct) begin
            p = {$urandom, $urandom, $urandom};
         end else if (roll < noise_pct + 10 && k > 0) begin
            p = picked[$urandom_range(0, k - 1)];
         end else begin
            p.x = center.x + jitter(spread);
            p.y = center.y + jitter(spread);
            p.z = center.z + jitter(spread);
         end
         picked[k] = p;
         queue_particle(p.x, p.y, p.z, k == count - 1);
      end
   endtask

   // Sets of mostly small sizes, spread so that roughly some of the pairs in
   // each set fall inside the current threshold.
   task automatic queue_random_sets(input int budget);
      int          size;
      int unsigned spread;
      spread = thr_model - thr_model / 4;
      while (budget > 0) begin
         size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 30);
         if (size > budget) size = budget;
         queue_cluster_set(size, spread, 15);
         budget -= size;
      end
   endtask

   // Waits until every queued request is accepted and every predicted record
   // has come back, then lets the block finish any request with no result.
   task automatic wait_until_drained();
      while (accepted_count < queued_count || expected_records.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset threshold (0.1). Directed set: exact boundary on both sides of
      // the threshold, negative differences, both coordinate extremes, and a
      // closing particle that matches nothing.
      verify_threshold();
      queue_particle(0, 0, 0, 1'b0);
      queue_particle(1677721, -1677721, 0, 1'b0);
      queue_particle(1677722, 0, 0, 1'b0);
      queue_particle(POS_MAX, POS_MAX, POS_MAX, 1'b0);
      queue_particle(POS_MAX, POS_MAX - 1677721, POS_MAX, 1'b0);
      queue_particle(POS_MIN, POS_MIN, POS_MIN, 1'b0);
      queue_particle(POS_MIN, POS_MIN, POS_MIN, 1'b0);
      queue_particle(POS_MAX, POS_MIN, 0, 1'b1);
      // A set of one particle: only a count record of zero pairs.
      queue_particle(POS_MIN, POS_MAX, -1, 1'b1);
      // A close pair whose pair record is followed by the count record.
      queue_particle(-5, 7, 0, 1'b0);
      queue_particle(-5 - 1677721, 7, 1677721, 1'b1);
      queue_random_sets(60);
      wait_until_drained();

      // Zero threshold: nothing can be close. The oversized set fills all
      // slots, drops the rest and ends on a dropped particle.
      write_threshold('0);
      verify_threshold();
      queue_cluster_set(66, 0, 50);
      queue_random_sets(10);
      wait_until_drained();

      // Largest threshold with a tight set of 65: every stored pair is
      // close, the pair count reaches 2016, short of its largest value, and the final
      // particle overflows. The receiver holds off in the middle of it.
      write_threshold(THR_MAX);
      verify_threshold();
      calm           = 1'b1;
      pressure_armed = 1'b1;
      queue_cluster_set(65, 1000, 0);
      wait_until_drained();
      calm = 1'b0;
      queue_random_sets(15);
      wait_until_drained();

      // A small random threshold with no idling on either side.
      write_threshold(THR_W'($urandom_range(2, 32'h0400_0000)));
      verify_threshold();
      calm = 1'b1;
      queue_random_sets(30);
      wait_until_drained();
      calm = 1'b0;

      // A random threshold over the whole range and a set that exactly
      // fills the store.
      write_threshold(THR_W'($urandom_range(1, 32'h7FFF_FFFE)));
      verify_threshold();
      queue_cluster_set(64, thr_model / 2, 10);
      queue_random_sets(20);
      wait_until_drained();

      // Threshold of one: only identical coordinates are close.
      write_threshold(THR_W'(1));
      verify_threshold();
      queue_random_sets(30);
      wait_until_drained();

      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
